// ----- src/kfe_pkg.sv -----
// Shared types, constants and register codes for the keypad frequency entry controller.
// No dependencies; every other file of the block imports this package.
package kfe_pkg;

    // Datapath widths
    localparam int VALUE_WIDTH = 16;
    localparam int FREQ_WIDTH  = 16;
    localparam int AMP_WIDTH   = 5;
    localparam int KEY_WIDTH   = 8;
    localparam int LEVEL_WIDTH = 8;
    localparam int CNT_WIDTH   = 3;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 16;

    // Entry digit limits
    localparam logic [CNT_WIDTH-1:0] MAX_DIGITS = 3'd5;
    localparam logic [CNT_WIDTH-1:0] COUNT_TOP  = 3'd7;

    // Fixed key codes
    localparam logic [KEY_WIDTH-1:0] KEY_STAR = 8'h2A;
    localparam logic [KEY_WIDTH-1:0] KEY_HASH = 8'h23;
    localparam logic [KEY_WIDTH-1:0] KEY_ZERO = 8'h30;
    localparam logic [KEY_WIDTH-1:0] KEY_NINE = 8'h39;

    // Divide by ten of a 16-bit entry: (x * 0xCCCD) >> 19 is exact over the full range
    localparam logic [VALUE_WIDTH-1:0] DIV10_MUL   = 16'hCCCD;
    localparam int                     DIV10_SHIFT = 19;

    // Input action codes
    localparam logic ACT_KEY     = 1'b0;
    localparam logic ACT_ENCODER = 1'b1;

    // Mode codes
    localparam logic MODE_SINE  = 1'b0;
    localparam logic MODE_PULSE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_SINE_KEY     = 3'd0,
        CFG_PULSE_KEY    = 3'd1,
        CFG_DEFAULTS_KEY = 3'd2,
        CFG_MIN_FREQ     = 3'd3,
        CFG_MAX_FREQ     = 3'd4,
        CFG_DEF_FREQ     = 3'd5,
        CFG_DEF_AMP      = 3'd6,
        CFG_MAX_AMP      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]  sine_key_code;
        logic [KEY_WIDTH-1:0]  pulse_key_code;
        logic [KEY_WIDTH-1:0]  defaults_key_code;
        logic [FREQ_WIDTH-1:0] min_frequency;
        logic [FREQ_WIDTH-1:0] max_frequency;
        logic [FREQ_WIDTH-1:0] default_frequency;
        logic [AMP_WIDTH-1:0]  default_amplitude;
        logic [AMP_WIDTH-1:0]  max_amplitude;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        sine_key_code:     8'd17,
        pulse_key_code:    8'd18,
        defaults_key_code: 8'd20,
        min_frequency:     16'd10,
        max_frequency:     16'd10000,
        default_frequency: 16'd1000,
        default_amplitude: 5'd10,
        max_amplitude:     5'd20
    };

    typedef struct packed {
        logic                 action;
        logic [KEY_WIDTH-1:0] key_code;
        logic                 turn_up;
    } t_in_item;

    typedef struct packed {
        logic                   mode;
        logic [VALUE_WIDTH-1:0] entry_value;
        logic                   entry_error;
        logic                   frequency_applied;
        logic [FREQ_WIDTH-1:0]  sine_frequency;
        logic [FREQ_WIDTH-1:0]  pulse_frequency;
        logic [AMP_WIDTH-1:0]   sine_amplitude;
        logic [AMP_WIDTH-1:0]   pulse_amplitude;
        logic [LEVEL_WIDTH-1:0] shown_level;
    } t_out_item;

endpackage

// ----- src/kfe_cfg_regs.sv -----
// Configuration register file of the keypad frequency entry controller.
// Depends on kfe_pkg for the register index codes and the t_cfg type.
module kfe_cfg_regs import kfe_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_wdata,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    // Write one register per enabled cycle; upper data bits dropped for narrow registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SINE_KEY:     r_cfg.sine_key_code     <= i_cfg_wdata[KEY_WIDTH-1:0];
                CFG_PULSE_KEY:    r_cfg.pulse_key_code    <= i_cfg_wdata[KEY_WIDTH-1:0];
                CFG_DEFAULTS_KEY: r_cfg.defaults_key_code <= i_cfg_wdata[KEY_WIDTH-1:0];
                CFG_MIN_FREQ:     r_cfg.min_frequency     <= i_cfg_wdata[FREQ_WIDTH-1:0];
                CFG_MAX_FREQ:     r_cfg.max_frequency     <= i_cfg_wdata[FREQ_WIDTH-1:0];
                CFG_DEF_FREQ:     r_cfg.default_frequency <= i_cfg_wdata[FREQ_WIDTH-1:0];
                CFG_DEF_AMP:      r_cfg.default_amplitude <= i_cfg_wdata[AMP_WIDTH-1:0];
                CFG_MAX_AMP:      r_cfg.max_amplitude     <= i_cfg_wdata[AMP_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/kfe_state.sv -----
// Panel state registers and combinational event update of the keypad frequency entry controller.
// Depends on kfe_pkg for key codes, widths and the item types.
module kfe_state import kfe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_step,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic                   r_mode, n_mode;
    logic [VALUE_WIDTH-1:0] r_entry, n_entry;
    logic [CNT_WIDTH-1:0]   r_count, n_count;
    logic                   r_has_digits, n_has_digits;
    logic [FREQ_WIDTH-1:0]  r_sine_freq, n_sine_freq;
    logic [FREQ_WIDTH-1:0]  r_pulse_freq, n_pulse_freq;
    logic [AMP_WIDTH-1:0]   r_sine_amp, n_sine_amp;
    logic [AMP_WIDTH-1:0]   r_pulse_amp, n_pulse_amp;
    logic                   n_err;
    logic                   n_applied;

    logic [2*VALUE_WIDTH-1:0] div_prod;
    logic [VALUE_WIDTH-1:0]   entry_div10;
    logic [VALUE_WIDTH+3:0]   entry_mac;
    logic [3:0]               digit;
    logic                     is_digit;
    logic                     enter_bad;
    logic [AMP_WIDTH-1:0]     amp_cur;
    logic [AMP_WIDTH-1:0]     amp_next;
    logic [LEVEL_WIDTH-1:0]   pulse_level;

    // Backspace: divide by ten through a reciprocal multiply
    assign div_prod    = r_entry * DIV10_MUL;
    assign entry_div10 = VALUE_WIDTH'(div_prod >> DIV10_SHIFT);

    // Digit append: entry * 10 + digit, wrapped to the entry width
    assign digit     = i_item.key_code[3:0];
    assign is_digit  = (i_item.key_code >= KEY_ZERO) && (i_item.key_code <= KEY_NINE);
    assign entry_mac = ({4'b0, r_entry} << 3) + ({4'b0, r_entry} << 1)
                     + (VALUE_WIDTH+4)'(digit);

    // Enter check against the limits and the digit count
    assign enter_bad = (r_entry < i_cfg.min_frequency) || (r_entry > i_cfg.max_frequency)
                     || (r_count > MAX_DIGITS);

    // Saturating amplitude step for the current mode
    assign amp_cur = (r_mode == MODE_PULSE) ? r_pulse_amp : r_sine_amp;
    always_comb begin
        amp_next = amp_cur;
        if (i_item.turn_up) begin
            if (amp_cur < i_cfg.max_amplitude) amp_next = amp_cur + 1'b1;
        end else begin
            if (amp_cur != '0) amp_next = amp_cur - 1'b1;
        end
    end

    // Next state: first matching key wins
    always_comb begin
        n_mode       = r_mode;
        n_entry      = r_entry;
        n_count      = r_count;
        n_has_digits = r_has_digits;
        n_sine_freq  = r_sine_freq;
        n_pulse_freq = r_pulse_freq;
        n_sine_amp   = r_sine_amp;
        n_pulse_amp  = r_pulse_amp;
        n_err        = 1'b0;
        n_applied    = 1'b0;
        if (i_item.action == ACT_ENCODER) begin
            if (r_mode == MODE_PULSE) n_pulse_amp = amp_next;
            else                      n_sine_amp  = amp_next;
        end else if (i_item.key_code == KEY_STAR) begin
            if (r_count != '0) n_count = r_count - 1'b1;
            if (r_count <= 3'd1) n_has_digits = 1'b0;
            n_entry = entry_div10;
        end else if (i_item.key_code == KEY_HASH) begin
            if (enter_bad) begin
                n_err = 1'b1;
            end else begin
                if (r_mode == MODE_PULSE) n_pulse_freq = r_entry;
                else                      n_sine_freq  = r_entry;
                n_applied = 1'b1;
            end
            n_entry      = '0;
            n_count      = '0;
            n_has_digits = 1'b0;
        end else if (is_digit) begin
            if (r_count < COUNT_TOP) n_count = r_count + 1'b1;
            n_has_digits = 1'b1;
            if (!r_has_digits) n_entry = VALUE_WIDTH'(digit);
            else               n_entry = entry_mac[VALUE_WIDTH-1:0];
        end else if (i_item.key_code == i_cfg.sine_key_code) begin
            n_mode       = MODE_SINE;
            n_count      = '0;
            n_has_digits = 1'b0;
        end else if (i_item.key_code == i_cfg.pulse_key_code) begin
            n_mode       = MODE_PULSE;
            n_count      = '0;
            n_has_digits = 1'b0;
        end else if (i_item.key_code == i_cfg.defaults_key_code) begin
            n_mode       = MODE_SINE;
            n_sine_freq  = i_cfg.default_frequency;
            n_pulse_freq = i_cfg.default_frequency;
            n_sine_amp   = i_cfg.default_amplitude;
            n_pulse_amp  = i_cfg.default_amplitude;
            n_entry      = '0;
            n_count      = '0;
            n_has_digits = 1'b0;
        end
    end

    // State registers, updated once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_SINE;
            r_entry      <= '0;
            r_count      <= '0;
            r_has_digits <= 1'b0;
            r_sine_freq  <= CFG_RESET.default_frequency;
            r_pulse_freq <= CFG_RESET.default_frequency;
            r_sine_amp   <= CFG_RESET.default_amplitude;
            r_pulse_amp  <= CFG_RESET.default_amplitude;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_entry      <= n_entry;
            r_count      <= n_count;
            r_has_digits <= n_has_digits;
            r_sine_freq  <= n_sine_freq;
            r_pulse_freq <= n_pulse_freq;
            r_sine_amp   <= n_sine_amp;
            r_pulse_amp  <= n_pulse_amp;
        end
    end

    // Result shows the state after the event; pulse level is steps times five
    assign pulse_level = (LEVEL_WIDTH'(n_pulse_amp) << 2) + LEVEL_WIDTH'(n_pulse_amp);

    always_comb begin
        o_result.mode              = n_mode;
        o_result.entry_value       = n_entry;
        o_result.entry_error       = n_err;
        o_result.frequency_applied = n_applied;
        o_result.sine_frequency    = n_sine_freq;
        o_result.pulse_frequency   = n_pulse_freq;
        o_result.sine_amplitude    = n_sine_amp;
        o_result.pulse_amplitude   = n_pulse_amp;
        o_result.shown_level       = (n_mode == MODE_PULSE) ? pulse_level
                                                            : LEVEL_WIDTH'(n_sine_amp);
    end

endmodule

// ----- src/keypad_frequency_entry_controller_core.sv -----
// Top level of the keypad frequency entry controller: input register, result register.
// Depends on kfe_pkg, kfe_cfg_regs and kfe_state.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) carries one panel event per item:
//   a key press or an encoder detent. Output channel (o_out_valid / i_out_ready / o_out)
//   returns exactly one result item per event, showing the panel state after it.
//   Configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_wdata,
//   one register per cycle; the user must write them only while no event is in flight,
//   as the block itself does not enforce it. An accepted item passes through the input
//   register and then the result register before its result appears on o_out.
//   Throughput: one item per cycle while i_out_ready stays high. The event update is a
//   single combinational pass from the input register into the state and result registers.
//   Stalls: while i_out_ready is low the result holds; the input register still takes
//   one more item, then o_in_ready drops until the result is taken.
//   Reset (synchronous, active low): both stages empty, configuration back to its
//   defaults, sine mode, empty entry, both frequencies 1000 and amplitudes 10.
module keypad_frequency_entry_controller_core import kfe_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  t_in_item                  i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output t_out_item                 o_out
);

    t_cfg      cfg;
    t_out_item step_result;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      advance;

    kfe_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Process the held item whenever the result slot is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    kfe_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (advance),
        .i_item   (r_in),
        .o_result (step_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Input stage only blocks while it holds an item that cannot move on
    a_ready_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked result");

    // An enter is either applied or rejected, never both
    a_enter_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.entry_error && o_out.frequency_applied))
        else $error("enter both applied and rejected");

    // Any enter leaves the entry cleared
    a_enter_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.entry_error || o_out.frequency_applied))
        |-> (o_out.entry_value == '0))
        else $error("entry not cleared after enter");

    // Shown level follows the current mode's amplitude
    a_level_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.shown_level == ((o_out.mode == MODE_PULSE)
            ? ((LEVEL_WIDTH'(o_out.pulse_amplitude) << 2) + LEVEL_WIDTH'(o_out.pulse_amplitude))
            : LEVEL_WIDTH'(o_out.sine_amplitude))))
        else $error("shown level does not match amplitude");

    // A processed item always produces a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("processed item produced no result");

endmodule
